[sv/ffa_pkg.sv]
// Shared types, codes and the padding function of the first-fit allocator.
// No dependencies; used by ffa_seg_cell and first_fit_free_list_allocator_core.
package ffa_pkg;

  localparam int HEADER_BYTES     = 16;
  localparam int HEADER_ALIGN_LG2 = 3;   // header alignment of 8 bytes
  localparam int MAX_ALIGN_LG2    = 12;
  localparam logic [16:0] POOL_MAX = 17'd65536;

  localparam logic [0:0] CMD_ALLOC = 1'b0;
  localparam logic [0:0] CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FIT  = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN = 2'd3;

  localparam logic [7:0] CFG_POOL_BASE  = 8'd0;
  localparam logic [7:0] CFG_POOL_BYTES = 8'd1;

  typedef enum logic [2:0] {
    SEG_HOLD,
    SEG_WRITE,
    SEG_REMOVE,
    SEG_MERGE,
    SEG_INSERT
  } seg_op_e;

  // Command broadcast to every segment cell; the target index travels beside it.
  typedef struct packed {
    seg_op_e     op;
    logic [31:0] start;
    logic [16:0] size;
  } seg_ctl_t;

  // Padding from a segment start to an aligned address that leaves room for a header.
  function automatic logic [12:0] pad_for(logic [11:0] addr, logic [3:0] lg);
    logic [3:0]  l;
    logic [12:0] act;
    logic [12:0] rem;
    logic [12:0] adj;
    logic [12:0] need;
    l = (lg > 4'(MAX_ALIGN_LG2)) ? 4'(MAX_ALIGN_LG2) : lg;
    if (l < 4'(HEADER_ALIGN_LG2)) begin
      l = 4'(HEADER_ALIGN_LG2);
    end
    act = 13'd1 << l;
    rem = {1'b0, addr} & (act - 13'd1);
    adj = (rem != 13'd0) ? (act - rem) : 13'd0;
    if (adj < 13'(HEADER_BYTES)) begin
      need = 13'(HEADER_BYTES) - adj + act - 13'd1;
      adj  = adj + ((need >> l) << l);
    end
    return adj;
  endfunction

endpackage

[sv/ffa_seg_cell.sv]
// One cell of the free-segment chain: holds one segment start and size.
// Depends on ffa_pkg for the command struct.
module ffa_seg_cell #(
  parameter int K     = 0,
  parameter int IDX_W = 5
) (
  input  logic                clk_i,
  input  ffa_pkg::seg_ctl_t   ctl_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic [31:0]         up_start_i,
  input  logic [16:0]         up_size_i,
  input  logic [31:0]         dn_start_i,
  input  logic [16:0]         dn_size_i,
  output logic [31:0]         start_o,
  output logic [16:0]         size_o
);

  localparam logic [IDX_W-1:0] KV  = IDX_W'(K);
  localparam logic [IDX_W-1:0] KV1 = IDX_W'(K + 1);

  logic [31:0] start_q, start_d;
  logic [16:0] size_q, size_d;

  always_comb begin
    start_d = start_q;
    size_d  = size_q;
    unique case (ctl_i.op)
      ffa_pkg::SEG_HOLD: begin
      end
      ffa_pkg::SEG_WRITE: begin
        if (idx_i == KV) begin
          start_d = ctl_i.start;
          size_d  = ctl_i.size;
        end
      end
      ffa_pkg::SEG_REMOVE: begin
        if (KV >= idx_i) begin
          start_d = up_start_i;
          size_d  = up_size_i;
        end
      end
      ffa_pkg::SEG_MERGE: begin
        // The lower neighbour absorbs the block, the upper one leaves the chain.
        if (KV1 == idx_i) begin
          start_d = ctl_i.start;
          size_d  = ctl_i.size;
        end else if (KV >= idx_i) begin
          start_d = up_start_i;
          size_d  = up_size_i;
        end
      end
      ffa_pkg::SEG_INSERT: begin
        if (KV == idx_i) begin
          start_d = ctl_i.start;
          size_d  = ctl_i.size;
        end else if (KV > idx_i) begin
          start_d = dn_start_i;
          size_d  = dn_size_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    size_q  <= size_d;
  end

  assign start_o = start_q;
  assign size_o  = size_q;

endmodule

[sv/first_fit_free_list_allocator_core.sv]
// Top level of the first-fit free-list allocator with coalescing.
// Depends on ffa_pkg and ffa_seg_cell.
//
//  channel  direction  handshake              payload
//  in       into core  in_valid_i/in_stall_o   command, request_size, align_log2,
//                                              release_address
//  out      from core  out_valid_o/out_stall_i granted_address, status,
//                                              used_bytes, live_count
//  cfg      into core  cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item is worked on at a time. An allocate scans the free segments in order until one
// fits, then commits. A free first looks up the address in the live table (one entry per
// cycle through its read port), then prepares the block, walks the segments and commits.
// After reset, and after any configuration write, the init state rebuilds the pool.
// A finished result waits in the output register while the next item is taken;
// the core only holds a new result back while the old one is still stalled.

module first_fit_free_list_allocator_core #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_LIVE     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  command_i,
  input  logic [15:0] request_size_i,
  input  logic [3:0]  align_log2_i,
  input  logic [31:0] release_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o,
  output logic [16:0] used_bytes_o,
  output logic [5:0]  live_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int SW  = $clog2(MAX_SEGMENTS);
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int LIW = $clog2(MAX_LIVE);
  localparam int LW  = $clog2(MAX_LIVE + 1);
  localparam int MW  = 32 + 17 + 13;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_ASCAN, ST_ACOMMIT, ST_FLOOK,
    ST_FPREP, ST_FSCAN, ST_FCOMMIT, ST_FIN
  } state_e;

  state_e state_q;

  logic [31:0] pool_base_q;
  logic [16:0] pool_bytes_q;
  logic [CW-1:0] seg_count_q;
  logic [MAX_LIVE-1:0] live_valid_q;
  logic [16:0] used_q;
  logic [LW-1:0] live_tot_q;

  // Item held while it is worked on.
  logic [15:0] req_q;
  logic [3:0]  lg_q;
  logic [31:0] rel_q;
  logic [LIW-1:0] slot_q;
  logic [CW-1:0] scan_q;

  // Allocate: the segment that fits.
  logic [31:0] f_start_q;
  logic [16:0] f_size_q;
  logic [12:0] f_adj_q;
  logic [17:0] f_total_q;

  // Free: lookup and neighbour search.
  logic [LIW:0]   lk_idx_q;
  logic [LIW-1:0] lk_cur_q;
  logic           lk_vld_q;
  logic [MW-1:0]  rd_q;
  logic [16:0] b_size_q;
  logic [12:0] b_pad_q;
  logic [31:0] b_start_q;
  logic [31:0] boff_q;
  logic [31:0] eoff_q;
  logic [31:0] prev_end_q;
  logic [31:0] prev_start_q;
  logic [16:0] prev_size_q;
  logic [16:0] hi_size_q;
  logic        mlo_q;
  logic        mhi_q;

  logic [31:0] res_addr_q;
  logic [1:0]  res_status_q;

  logic        out_valid_q;
  logic [31:0] out_addr_q;
  logic [1:0]  out_status_q;
  logic [16:0] out_used_q;
  logic [5:0]  out_live_q;

  logic [MW-1:0] live_mem [MAX_LIVE];

  // Segment chain.
  logic [31:0] seg_start [MAX_SEGMENTS];
  logic [16:0] seg_size  [MAX_SEGMENTS];
  ffa_pkg::seg_ctl_t seg_ctl;
  logic [CW-1:0]     seg_idx;

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    logic [31:0] up_start, dn_start;
    logic [16:0] up_size, dn_size;
    if (k == MAX_SEGMENTS - 1) begin : g_top
      assign up_start = '0;
      assign up_size  = '0;
    end else begin : g_mid
      assign up_start = seg_start[k+1];
      assign up_size  = seg_size[k+1];
    end
    if (k == 0) begin : g_bot
      assign dn_start = '0;
      assign dn_size  = '0;
    end else begin : g_low
      assign dn_start = seg_start[k-1];
      assign dn_size  = seg_size[k-1];
    end
    ffa_seg_cell #(
      .K     (k),
      .IDX_W (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (seg_ctl),
      .idx_i      (seg_idx),
      .up_start_i (up_start),
      .up_size_i  (up_size),
      .dn_start_i (dn_start),
      .dn_size_i  (dn_size),
      .start_o    (seg_start[k]),
      .size_o     (seg_size[k])
    );
  end

  // The scan reads the chain at one position per cycle.
  logic [31:0] rd_start;
  logic [16:0] rd_size;
  assign rd_start = seg_start[scan_q[SW-1:0]];
  assign rd_size  = seg_size[scan_q[SW-1:0]];

  // Pool setup from the configuration registers.
  logic [16:0] init_bytes;
  logic [16:0] init_adj;
  assign init_bytes = (pool_bytes_q > ffa_pkg::POOL_MAX) ? ffa_pkg::POOL_MAX : pool_bytes_q;
  assign init_adj   = (pool_base_q[2:0] != 3'd0) ? (17'd8 - 17'({pool_base_q[2:0]})) : 17'd0;

  // Allocate scan arithmetic.
  logic [12:0] a_adj;
  logic [17:0] a_total;
  logic        a_fit;
  assign a_adj   = ffa_pkg::pad_for(rd_start[11:0], lg_q);
  assign a_total = 18'(req_q) + 18'(a_adj);
  assign a_fit   = 18'(rd_size) >= a_total;

  // Allocate commit: the whole segment goes when the rest would be no larger than a header.
  logic [16:0] c_rem;
  logic        c_whole;
  logic [16:0] c_total;
  assign c_rem   = f_size_q - f_total_q[16:0];
  assign c_whole = c_rem <= 17'(ffa_pkg::HEADER_BYTES);
  assign c_total = c_whole ? f_size_q : f_total_q[16:0];

  // Free scan.
  logic [31:0] s_off;
  assign s_off = rd_start - pool_base_q;

  logic [31:0] lk_addr;
  logic [16:0] lk_size;
  logic [12:0] lk_pad;
  assign lk_addr = rd_q[MW-1 -: 32];
  assign lk_size = rd_q[29:13];
  assign lk_pad  = rd_q[12:0];

  logic seg_full;
  assign seg_full = seg_count_q >= CW'(MAX_SEGMENTS);

  // Lowest free slot of the live table.
  logic           free_found;
  logic [LIW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = MAX_LIVE - 1; s >= 0; s--) begin
      if (!live_valid_q[s]) begin
        free_found = 1'b1;
        free_slot  = LIW'(s);
      end
    end
  end

  logic in_acc, cfg_acc, out_free;
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Chain command for this cycle.
  always_comb begin
    seg_ctl.op    = ffa_pkg::SEG_HOLD;
    seg_ctl.start = '0;
    seg_ctl.size  = '0;
    seg_idx       = scan_q;
    unique case (state_q)
      ST_INIT: begin
        seg_ctl.op    = ffa_pkg::SEG_WRITE;
        seg_ctl.start = pool_base_q + 32'(init_adj);
        seg_ctl.size  = init_bytes - init_adj;
        seg_idx       = '0;
      end
      ST_ACOMMIT: begin
        if (c_whole) begin
          seg_ctl.op = ffa_pkg::SEG_REMOVE;
        end else begin
          seg_ctl.op    = ffa_pkg::SEG_WRITE;
          seg_ctl.start = f_start_q + 32'(f_total_q);
          seg_ctl.size  = c_rem;
        end
      end
      ST_FCOMMIT: begin
        priority if (mlo_q && mhi_q) begin
          seg_ctl.op    = ffa_pkg::SEG_MERGE;
          seg_ctl.start = prev_start_q;
          seg_ctl.size  = prev_size_q + b_size_q + hi_size_q;
        end else if (mlo_q) begin
          seg_ctl.op    = ffa_pkg::SEG_WRITE;
          seg_ctl.start = prev_start_q;
          seg_ctl.size  = prev_size_q + b_size_q;
          seg_idx       = scan_q - CW'(1);
        end else if (mhi_q) begin
          seg_ctl.op    = ffa_pkg::SEG_WRITE;
          seg_ctl.start = b_start_q;
          seg_ctl.size  = hi_size_q + b_size_q;
        end else if (!seg_full) begin
          seg_ctl.op    = ffa_pkg::SEG_INSERT;
          seg_ctl.start = b_start_q;
          seg_ctl.size  = b_size_q;
        end else begin
          seg_ctl.op = ffa_pkg::SEG_HOLD;
        end
      end
      default: begin
      end
    endcase
  end

  // Live table: written when an allocate commits, read one entry per cycle by a free.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACOMMIT) begin
      live_mem[slot_q] <= {f_start_q + 32'(f_adj_q), c_total, f_adj_q};
    end
    rd_q <= live_mem[lk_idx_q[LIW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      pool_base_q  <= '0;
      pool_bytes_q <= ffa_pkg::POOL_MAX;
      seg_count_q  <= '0;
      live_valid_q <= '0;
      used_q       <= '0;
      live_tot_q   <= '0;
      lk_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // The finish state loads the output register itself when it is taken.
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          seg_count_q  <= (init_bytes > init_adj) ? CW'(1) : CW'(0);
          live_valid_q <= '0;
          used_q       <= '0;
          live_tot_q   <= '0;
          state_q      <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index_i == ffa_pkg::CFG_POOL_BASE) begin
              pool_base_q <= cfg_data_i;
              state_q     <= ST_INIT;
            end else if (cfg_index_i == ffa_pkg::CFG_POOL_BYTES) begin
              pool_bytes_q <= cfg_data_i[16:0];
              state_q      <= ST_INIT;
            end
          end else if (in_acc) begin
            req_q    <= request_size_i;
            lg_q     <= align_log2_i;
            rel_q    <= release_address_i;
            scan_q   <= '0;
            lk_idx_q <= '0;
            lk_vld_q <= 1'b0;
            if (command_i == ffa_pkg::CMD_FREE) begin
              state_q <= ST_FLOOK;
            end else if (!free_found) begin
              res_addr_q   <= '0;
              res_status_q <= ffa_pkg::STAT_FULL;
              state_q      <= ST_FIN;
            end else begin
              slot_q  <= free_slot;
              state_q <= ST_ASCAN;
            end
          end
        end
        ST_ASCAN: begin
          if (scan_q >= seg_count_q) begin
            res_addr_q   <= '0;
            res_status_q <= ffa_pkg::STAT_NO_FIT;
            state_q      <= ST_FIN;
          end else if (a_fit) begin
            f_start_q <= rd_start;
            f_size_q  <= rd_size;
            f_adj_q   <= a_adj;
            f_total_q <= a_total;
            state_q   <= ST_ACOMMIT;
          end else begin
            scan_q <= scan_q + CW'(1);
          end
        end
        ST_ACOMMIT: begin
          if (c_whole) begin
            seg_count_q <= seg_count_q - CW'(1);
          end
          live_valid_q[slot_q] <= 1'b1;
          used_q       <= used_q + c_total;
          live_tot_q   <= live_tot_q + LW'(1);
          res_addr_q   <= f_start_q + 32'(f_adj_q);
          res_status_q <= ffa_pkg::STAT_OK;
          state_q      <= ST_FIN;
        end
        ST_FLOOK: begin
          if (lk_idx_q < (LIW+1)'(MAX_LIVE)) begin
            lk_cur_q <= lk_idx_q[LIW-1:0];
            lk_vld_q <= 1'b1;
            lk_idx_q <= lk_idx_q + (LIW+1)'(1);
          end else begin
            lk_vld_q <= 1'b0;
          end
          if (lk_vld_q && live_valid_q[lk_cur_q] && (lk_addr == rel_q)) begin
            slot_q   <= lk_cur_q;
            b_size_q <= lk_size;
            b_pad_q  <= lk_pad;
            state_q  <= ST_FPREP;
          end else if (lk_vld_q && (lk_cur_q == LIW'(MAX_LIVE - 1))) begin
            res_addr_q   <= '0;
            res_status_q <= ffa_pkg::STAT_UNKNOWN;
            state_q      <= ST_FIN;
          end
        end
        ST_FPREP: begin
          b_start_q <= rel_q - 32'(b_pad_q);
          boff_q    <= rel_q - 32'(b_pad_q) - pool_base_q;
          eoff_q    <= rel_q - 32'(b_pad_q) - pool_base_q + 32'(b_size_q);
          scan_q    <= '0;
          state_q   <= ST_FSCAN;
        end
        ST_FSCAN: begin
          // Walk in address order, keeping the segment below the block at hand.
          if (scan_q >= seg_count_q) begin
            mlo_q   <= (scan_q != '0) && (prev_end_q == boff_q);
            mhi_q   <= 1'b0;
            state_q <= ST_FCOMMIT;
          end else if (s_off >= eoff_q) begin
            mlo_q     <= (scan_q != '0) && (prev_end_q == boff_q);
            mhi_q     <= (s_off == eoff_q);
            hi_size_q <= rd_size;
            state_q   <= ST_FCOMMIT;
          end else begin
            prev_end_q   <= s_off + 32'(rd_size);
            prev_start_q <= rd_start;
            prev_size_q  <= rd_size;
            scan_q       <= scan_q + CW'(1);
          end
        end
        ST_FCOMMIT: begin
          res_addr_q <= '0;
          if (!mlo_q && !mhi_q && seg_full) begin
            // No room for a separate segment: the allocation stays live.
            res_status_q <= ffa_pkg::STAT_FULL;
          end else begin
            if (mlo_q && mhi_q) begin
              seg_count_q <= seg_count_q - CW'(1);
            end else if (!mlo_q && !mhi_q) begin
              seg_count_q <= seg_count_q + CW'(1);
            end
            live_valid_q[slot_q] <= 1'b0;
            live_tot_q   <= live_tot_q - LW'(1);
            used_q       <= used_q - b_size_q;
            res_status_q <= ffa_pkg::STAT_OK;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_addr_q   <= res_addr_q;
            out_status_q <= res_status_q;
            out_used_q   <= used_q;
            out_live_q   <= 6'(live_tot_q);
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_INIT;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;
  assign used_bytes_o      = out_used_q;
  assign live_count_o      = out_live_q;

  // The segment count never exceeds the chain length.
  a_seg_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_count_q <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond chain length");

  // The live counter tracks the valid bits of the live table.
  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(live_valid_q) == int'(live_tot_q))
    else $error("live counter out of step with live table");

  // An accepted item blocks the input until its result is produced.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken while one is at work");

  // A result leaves the finish state only into a free output register.
  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> out_valid_q)
    else $error("finished result not presented");

endmodule
